### rtl/pmbus_psu_i2c_target_unit_macros.svh
// Assertion macros shared by the RTL. Each macro expects clk and rst in scope.
`ifndef PMBUS_PSU_I2C_TARGET_UNIT_MACROS_SVH
`define PMBUS_PSU_I2C_TARGET_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMBPSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMBPSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pmbpsu_pkg.sv
package pmbpsu_pkg;

  typedef enum logic [2:0] {
    OP_START_RX = 3'd0,
    OP_START_TX = 3'd1,
    OP_NACK     = 3'd2,
    OP_FINISH   = 3'd3,
    OP_SEND     = 3'd4,
    OP_RECV     = 3'd5
  } op_t;

  localparam int FILL_MAX = 8;
  localparam int FILL_LEN_W = 4;

  localparam logic [7:0] CARD_ID_CMD = 8'hBD;
  localparam logic [7:0] FW_FIRST_CMD = 8'hFA;
  localparam logic [7:0] FW_LAST_CMD = 8'hFD;
  localparam logic [7:0] SYS_CFG_CMD = 8'hDA;
  localparam logic [7:0] IN_HIST_CMD = 8'hD6;
  localparam logic [7:0] POINTER_IDLE = 8'hFF;
  localparam logic [7:0] READ_PAST_END = 8'hFF;
  localparam logic [31:0] FW_WORD = 32'h0403_0201;
  localparam logic [15:0] CARD_ID = 16'h2B1D;

  // Count byte first, then the ASCII text.
  localparam logic [7:0] MODEL_STR [8] =
    '{8'd7, 8'h46, 8'h52, 8'h55, 8'h30, 8'h31, 8'h32, 8'h33};
  localparam logic [7:0] PART_STR [8] =
    '{8'd7, 8'h50, 8'h41, 8'h52, 8'h30, 8'h31, 8'h32, 8'h33};
  localparam logic [7:0] SERIAL_STR [7] =
    '{8'd6, 8'h58, 8'h59, 8'h5A, 8'h30, 8'h31, 8'h32};

  typedef struct packed {
    logic [FILL_LEN_W-1:0] len;
    logic [FILL_MAX-1:0][7:0] bytes;
  } fill_t;

endpackage

### rtl/pmbpsu_fill.sv
module pmbpsu_fill #(
  parameter int MODEL_CMD = 154,
  parameter int REVISION_CMD = 155,
  parameter int SERIAL_CMD = 158
) (
  input  logic [7:0]         ptr,
  input  logic [7:0]         sys_cfg,
  output pmbpsu_pkg::fill_t  fill
);

  logic [1:0] fw_sel;

  assign fw_sel = 2'(ptr - pmbpsu_pkg::FW_FIRST_CMD);

  always_comb begin
    fill = '0;
    priority if (ptr == 8'(MODEL_CMD)) begin
      fill.len = 4'd8;
      for (int i = 0; i < 8; i++) fill.bytes[i] = pmbpsu_pkg::MODEL_STR[i];
    end else if (ptr == 8'(REVISION_CMD)) begin
      fill.len = 4'd8;
      for (int i = 0; i < 8; i++) fill.bytes[i] = pmbpsu_pkg::PART_STR[i];
    end else if (ptr == 8'(SERIAL_CMD)) begin
      fill.len = 4'd7;
      for (int i = 0; i < 7; i++) fill.bytes[i] = pmbpsu_pkg::SERIAL_STR[i];
    end else if (ptr == pmbpsu_pkg::CARD_ID_CMD) begin
      fill.len = 4'd2;
      fill.bytes[0] = pmbpsu_pkg::CARD_ID[15:8];
      fill.bytes[1] = pmbpsu_pkg::CARD_ID[7:0];
    end else if (ptr >= pmbpsu_pkg::FW_FIRST_CMD && ptr <= pmbpsu_pkg::FW_LAST_CMD) begin
      // The lowest pointer of the range returns the most significant byte.
      fill.len = 4'd1;
      fill.bytes[0] = pmbpsu_pkg::FW_WORD[{~fw_sel, 3'b000} +: 8];
    end else if (ptr == pmbpsu_pkg::IN_HIST_CMD) begin
      fill.len = 4'd1;
      fill.bytes[0] = 8'h00;
    end else begin
      fill.len = 4'd1;
      fill.bytes[0] = (ptr == pmbpsu_pkg::SYS_CFG_CMD) ? sys_cfg : 8'h00;
    end
  end

endmodule

### rtl/pmbus_psu_i2c_target_unit.sv
// Each item passes through an input register, then a result register, before its result
// is presented on m_tdata.
// Throughput: one item per cycle while m_tready does not stall the output; the state update is not pipelined.
// Reset (synchronous, rst high): the command pointer goes to 0xFF, the byte
// count and system config to zero, and every transfer buffer entry is cleared.
module pmbus_psu_i2c_target_unit #(
  parameter int BUF_DEPTH = 32,
  parameter int MODEL_CMD = 154,
  parameter int REVISION_CMD = 155,
  parameter int SERIAL_CMD = 158
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_in
  input  logic [2:0] s_tuser,   // [2:0] op
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [7:0] read_data
);

  `include "pmbus_psu_i2c_target_unit_macros.svh"

  localparam int CNT_W = $clog2(BUF_DEPTH + 2);
  localparam int IDX_W = $clog2(BUF_DEPTH);

  logic             in_valid;
  logic [2:0]       in_op;
  logic [7:0]       in_data;
  logic             advance;
  logic             work;

  logic [7:0]       cmd_pointer;
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic [7:0]       sys_cfg;
  logic [7:0]       xfer_buffer [BUF_DEPTH];

  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             cnt_in_buf;
  logic             cnt_below_end;
  logic [7:0]       rd_byte;
  pmbpsu_pkg::op_t  op;
  pmbpsu_pkg::fill_t fill;

  pmbpsu_fill #(
    .MODEL_CMD   (MODEL_CMD),
    .REVISION_CMD(REVISION_CMD),
    .SERIAL_CMD  (SERIAL_CMD)
  ) u_fill (
    .ptr    (cmd_pointer),
    .sys_cfg(sys_cfg),
    .fill   (fill)
  );

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign work     = in_valid && advance;
  assign op       = pmbpsu_pkg::op_t'(in_op);

  assign cnt_m1        = byte_count - CNT_W'(1);
  assign wr_idx        = cnt_m1[IDX_W-1:0];
  assign rd_idx        = byte_count[IDX_W-1:0];
  assign cnt_in_buf    = byte_count <= CNT_W'(BUF_DEPTH);
  assign cnt_below_end = byte_count < CNT_W'(BUF_DEPTH);

  always_comb begin
    rd_byte = 8'h00;
    if (op == pmbpsu_pkg::OP_RECV) begin
      rd_byte = cnt_below_end ? xfer_buffer[rd_idx] : pmbpsu_pkg::READ_PAST_END;
    end
  end

  always_comb begin
    byte_count_next = byte_count;
    unique case (op)
      pmbpsu_pkg::OP_START_RX,
      pmbpsu_pkg::OP_START_TX,
      pmbpsu_pkg::OP_NACK,
      pmbpsu_pkg::OP_FINISH: byte_count_next = '0;
      pmbpsu_pkg::OP_SEND: begin
        // Saturates one past the buffer so later data bytes are dropped.
        if (cnt_in_buf) byte_count_next = byte_count + CNT_W'(1);
      end
      pmbpsu_pkg::OP_RECV: begin
        if (cnt_below_end) byte_count_next = byte_count + CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_data <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
    if (work) begin
      m_tdata <= rd_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_pointer <= pmbpsu_pkg::POINTER_IDLE;
      byte_count  <= '0;
      sys_cfg     <= 8'h00;
    end else if (work) begin
      byte_count <= byte_count_next;
      unique case (op)
        pmbpsu_pkg::OP_START_TX,
        pmbpsu_pkg::OP_NACK,
        pmbpsu_pkg::OP_FINISH: cmd_pointer <= pmbpsu_pkg::POINTER_IDLE;
        pmbpsu_pkg::OP_SEND: begin
          if (byte_count == '0) begin
            cmd_pointer <= in_data;
          end else if (cmd_pointer == pmbpsu_pkg::SYS_CFG_CMD) begin
            // Takes buffer entry 0 as it stands after this byte is written.
            sys_cfg <= (byte_count == CNT_W'(1)) ? in_data : xfer_buffer[0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUF_DEPTH; i++) xfer_buffer[i] <= 8'h00;
    end else if (work) begin
      unique case (op)
        pmbpsu_pkg::OP_START_RX: begin
          for (int i = 0; i < pmbpsu_pkg::FILL_MAX; i++) begin
            if (i < int'(fill.len)) xfer_buffer[i] <= fill.bytes[i];
          end
        end
        pmbpsu_pkg::OP_SEND: begin
          if (byte_count != '0 && cnt_in_buf) xfer_buffer[wr_idx] <= in_data;
        end
        default: ;
      endcase
    end
  end

  `PMBPSU_ASSERT_NOW(a_count_bound, 1'b1, byte_count <= CNT_W'(BUF_DEPTH + 1),
    "byte count beyond saturation")
  `PMBPSU_ASSERT_NEXT(a_recv_past_end,
    work && op == pmbpsu_pkg::OP_RECV && !cnt_below_end,
    m_tdata == pmbpsu_pkg::READ_PAST_END && byte_count == $past(byte_count),
    "receive past end must return 0xFF and hold the count")
  `PMBPSU_ASSERT_NEXT(a_non_recv_zero, work && op != pmbpsu_pkg::OP_RECV,
    m_tdata == 8'h00 && m_tvalid, "non-receive item must return zero")
  `PMBPSU_ASSERT_NEXT(a_bus_event_reset,
    work && (op == pmbpsu_pkg::OP_START_TX || op == pmbpsu_pkg::OP_NACK ||
    op == pmbpsu_pkg::OP_FINISH),
    cmd_pointer == pmbpsu_pkg::POINTER_IDLE && byte_count == '0,
    "bus event must park the pointer and clear the count")

endmodule
